### design/rems_pkg.sv
`default_nettype none

package rems_pkg;

  localparam int unsigned EDGE_W  = 11;
  localparam int unsigned COORD_W = 10;
  localparam int unsigned CFG_W   = 11;
  // wide enough for any size register value and for parameter maxima below 8192
  localparam int unsigned SIZE_W  = 13;

  localparam logic [EDGE_W-1:0] EDGE_SAT  = 11'd2047;
  localparam logic [EDGE_W-1:0] MIN_RESET = 11'd2040;
  localparam logic [CFG_W-1:0]  SIZE_RESET = 11'd512;

  // register indexes on the configuration port
  localparam logic REG_NUM_ROWS = 1'b0;
  localparam logic REG_NUM_COLS = 1'b1;

  // windows that one pixel can complete, in emission order; the value is
  // also the bit position in a job's window mask
  typedef enum logic [1:0] {
    WIN_ABOVE_LEFT = 2'd0,
    WIN_ABOVE      = 2'd1,
    WIN_LEFT       = 2'd2,
    WIN_HERE       = 2'd3
  } win_e;

  typedef struct packed {
    logic             restart;
    logic [CFG_W-1:0] num_rows;
    logic [CFG_W-1:0] num_cols;
  } cfg_t;

  typedef struct packed {
    logic [EDGE_W-1:0]  edge_res;
    logic [COORD_W-1:0] out_row;
    logic [COORD_W-1:0] out_col;
    logic               last_of_run;
    logic               frame_done;
    logic [EDGE_W-1:0]  frame_min;
    logic [EDGE_W-1:0]  frame_max;
  } result_t;

endpackage

`default_nettype wire

### design/rems_fifo.sv
`default_nettype none

module rems_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic [WIDTH-1:0]      rdata_o,
  output logic                  empty_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] store_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign empty_o = (count_q == '0);
  assign rdata_o = store_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      store_q[wr_ptr_q] <= wdata_i;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("fifo count beyond depth");

endmodule

`default_nettype wire

### design/rems_front.sv
`default_nettype none

module rems_front #(
  parameter int unsigned MAX_COLS   = 1024,
  parameter int unsigned MAX_ROWS   = 1024,
  parameter int unsigned PIXEL_BITS = 8,
  localparam int unsigned COL_W = $clog2(MAX_COLS),
  localparam int unsigned ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1,
  localparam int unsigned JOB_W = 4 * PIXEL_BITS + ROW_W + COL_W + 4
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire rems_pkg::cfg_t    cfg_i,
  input  wire logic              push_i,
  input  wire logic [7:0]        pixel_i,
  output logic                   full_o,
  output logic                   jq_push_o,
  output logic [JOB_W-1:0]       jq_data_o,
  input  wire logic              jq_full_i
);

  import rems_pkg::*;

  localparam int unsigned PW = PIXEL_BITS;

  typedef struct packed {
    logic [PW-1:0]    pix;
    logic [PW-1:0]    up;
    logic [PW-1:0]    left;
    logic [PW-1:0]    ul;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic [3:0]       mask;
  } job_t;

  logic [PW-1:0]     line_mem [MAX_COLS];
  logic [PW-1:0]     up_q;
  logic [PW-1:0]     pix;
  logic [SIZE_W-1:0] rows_eff, cols_eff;
  logic              last_col, last_row, accept;
  logic [COL_W-1:0]  col_q, col_d;
  logic [ROW_W-1:0]  row_q, row_d;
  logic              s1_valid_q, s1_valid_d, s1_adv;
  logic [PW-1:0]     s1_pix_q;
  logic [ROW_W-1:0]  s1_row_q;
  logic [COL_W-1:0]  s1_col_q;
  logic [3:0]        s1_mask_q, mask_d;
  logic [PW-1:0]     left_q, ul_q;
  job_t              job;

  assign pix = PW'(pixel_i);

  // zero acts as one, oversize as the maximum
  always_comb begin
    if (cfg_i.num_rows == '0) begin
      rows_eff = SIZE_W'(1);
    end else if (SIZE_W'(cfg_i.num_rows) > SIZE_W'(MAX_ROWS)) begin
      rows_eff = SIZE_W'(MAX_ROWS);
    end else begin
      rows_eff = SIZE_W'(cfg_i.num_rows);
    end
    if (cfg_i.num_cols == '0) begin
      cols_eff = SIZE_W'(1);
    end else if (SIZE_W'(cfg_i.num_cols) > SIZE_W'(MAX_COLS)) begin
      cols_eff = SIZE_W'(MAX_COLS);
    end else begin
      cols_eff = SIZE_W'(cfg_i.num_cols);
    end
  end

  assign last_col = (SIZE_W'(col_q) + SIZE_W'(1)) >= cols_eff;
  assign last_row = (SIZE_W'(row_q) + SIZE_W'(1)) >= rows_eff;

  assign s1_adv  = s1_valid_q && (!jq_full_i || (s1_mask_q == '0));
  assign full_o  = s1_valid_q && !s1_adv;
  assign accept  = push_i && !full_o;

  always_comb begin
    mask_d                 = '0;
    mask_d[WIN_ABOVE_LEFT] = (row_q != '0) && (col_q != '0);
    mask_d[WIN_ABOVE]      = (row_q != '0) && last_col;
    mask_d[WIN_LEFT]       = last_row && (col_q != '0);
    mask_d[WIN_HERE]       = last_row && last_col;
  end

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (cfg_i.restart) begin
      col_d = '0;
      row_d = '0;
    end else if (accept) begin
      if (last_col) begin
        col_d = '0;
        row_d = last_row ? '0 : row_q + ROW_W'(1);
      end else begin
        col_d = col_q + COL_W'(1);
      end
    end
  end

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      s1_valid_q <= 1'b0;
      left_q     <= '0;
      ul_q       <= '0;
    end else begin
      col_q      <= col_d;
      row_q      <= row_d;
      s1_valid_q <= s1_valid_d;
      if (s1_adv) begin
        left_q <= s1_pix_q;
        ul_q   <= up_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_pix_q  <= pix;
      s1_row_q  <= row_q;
      s1_col_q  <= col_q;
      s1_mask_q <= mask_d;
    end
  end

  // line store: old value read out while the new pixel is written
  always_ff @(posedge clk_i) begin
    if (accept) begin
      up_q           <= line_mem[col_q];
      line_mem[col_q] <= pix;
    end
  end

  always_comb begin
    job.pix  = s1_pix_q;
    job.up   = up_q;
    job.left = left_q;
    job.ul   = ul_q;
    job.row  = s1_row_q;
    job.col  = s1_col_q;
    job.mask = s1_mask_q;
  end

  assign jq_push_o = s1_valid_q && (s1_mask_q != '0) && !jq_full_i;
  assign jq_data_o = job;

  a_col_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    SIZE_W'(col_q) < cols_eff)
    else $error("column counter beyond image width");

  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && jq_full_i && (s1_mask_q != '0)
    |=> s1_valid_q && $stable(s1_pix_q) && $stable(up_q))
    else $error("stalled pixel lost its window data");

endmodule

`default_nettype wire

### design/rems_back.sv
`default_nettype none

module rems_back #(
  parameter int unsigned MAX_COLS   = 1024,
  parameter int unsigned MAX_ROWS   = 1024,
  parameter int unsigned PIXEL_BITS = 8,
  localparam int unsigned COL_W = $clog2(MAX_COLS),
  localparam int unsigned ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1,
  localparam int unsigned JOB_W = 4 * PIXEL_BITS + ROW_W + COL_W + 4
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               restart_i,
  input  wire logic               jq_empty_i,
  input  wire logic [JOB_W-1:0]   jq_data_i,
  output logic                    jq_pop_o,
  output logic                    res_push_o,
  output rems_pkg::result_t       res_o,
  input  wire logic               res_full_i
);

  import rems_pkg::*;

  localparam int unsigned PW    = PIXEL_BITS;
  localparam int unsigned DIF_W = PW + 2;
  localparam int unsigned SUM_W = PW + 3;
  localparam int unsigned CMP_W = (SUM_W > 12) ? SUM_W : 12;

  typedef struct packed {
    logic [PW-1:0]    pix;
    logic [PW-1:0]    up;
    logic [PW-1:0]    left;
    logic [PW-1:0]    ul;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic [3:0]       mask;
  } job_t;

  job_t               job;
  logic               busy_q, busy_d;
  logic [3:0]         rem_q, rem_d, sel_mask, new_rem;
  win_e               win;
  logic               issue, b_adv;
  logic [PW-1:0]      op_a, op_b, op_c, op_d;
  logic [ROW_W-1:0]   win_row;
  logic [COL_W-1:0]   win_col;
  logic signed [DIF_W-1:0] sa, sb, sc, sd, h, v, ld;
  logic [DIF_W-1:0]   habs, vabs, ldabs;
  logic [SUM_W-1:0]   sum;
  logic [EDGE_W-1:0]  edge_d;

  logic               b_valid_q, b_valid_d;
  logic [EDGE_W-1:0]  b_edge_q;
  logic [COORD_W-1:0] b_row_q, b_col_q;
  logic               b_last_q, b_done_q;
  logic [EDGE_W-1:0]  run_min_q, run_max_q, new_min, new_max;

  assign job = jq_data_i;

  // next window of the head job: lowest set bit still pending
  always_comb begin
    sel_mask = busy_q ? rem_q : job.mask;
    win      = WIN_HERE;
    if (sel_mask[WIN_LEFT]) begin
      win = WIN_LEFT;
    end
    if (sel_mask[WIN_ABOVE]) begin
      win = WIN_ABOVE;
    end
    if (sel_mask[WIN_ABOVE_LEFT]) begin
      win = WIN_ABOVE_LEFT;
    end
    new_rem = sel_mask & ~(4'b0001 << win);
  end

  assign b_adv    = !b_valid_q || !res_full_i;
  assign issue    = !jq_empty_i && b_adv;
  assign jq_pop_o = issue && (new_rem == '0);

  always_comb begin
    busy_d = busy_q;
    rem_d  = rem_q;
    if (restart_i) begin
      busy_d = 1'b0;
    end else if (issue) begin
      busy_d = (new_rem != '0);
      rem_d  = new_rem;
    end
  end

  always_comb begin
    case (win)
      WIN_ABOVE_LEFT: begin
        op_a = job.ul;   op_b = job.up;  op_c = job.left; op_d = job.pix;
        win_row = job.row - ROW_W'(1);
        win_col = job.col - COL_W'(1);
      end
      WIN_ABOVE: begin
        op_a = job.up;   op_b = job.up;  op_c = job.pix;  op_d = job.pix;
        win_row = job.row - ROW_W'(1);
        win_col = job.col;
      end
      WIN_LEFT: begin
        op_a = job.left; op_b = job.pix; op_c = job.left; op_d = job.pix;
        win_row = job.row;
        win_col = job.col - COL_W'(1);
      end
      default: begin
        op_a = job.pix;  op_b = job.pix; op_c = job.pix;  op_d = job.pix;
        win_row = job.row;
        win_col = job.col;
      end
    endcase
  end

  // |H| + |V| + 2|LD|; the right diagonal mirrors the left one
  always_comb begin
    sa    = $signed({2'b00, op_a});
    sb    = $signed({2'b00, op_b});
    sc    = $signed({2'b00, op_c});
    sd    = $signed({2'b00, op_d});
    h     = sa + sb - sc - sd;
    v     = sa - sb + sc - sd;
    ld    = sa - sb - sc + sd;
    habs  = h[DIF_W-1]  ? DIF_W'(-h)  : DIF_W'(h);
    vabs  = v[DIF_W-1]  ? DIF_W'(-v)  : DIF_W'(v);
    ldabs = ld[DIF_W-1] ? DIF_W'(-ld) : DIF_W'(ld);
    sum   = SUM_W'(habs) + SUM_W'(vabs) + (SUM_W'(ldabs) << 1);
    if (CMP_W'(sum) > CMP_W'(EDGE_SAT)) begin
      edge_d = EDGE_SAT;
    end else begin
      edge_d = EDGE_W'(sum);
    end
  end

  always_comb begin
    b_valid_d = b_valid_q;
    if (issue) begin
      b_valid_d = 1'b1;
    end else if (b_adv) begin
      b_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      b_edge_q <= edge_d;
      b_row_q  <= COORD_W'(win_row);
      b_col_q  <= COORD_W'(win_col);
      b_last_q <= (new_rem == '0);
      b_done_q <= (win == WIN_HERE);
    end
  end

  // running frame extremes include the result being sent
  assign new_min = (b_edge_q < run_min_q) ? b_edge_q : run_min_q;
  assign new_max = (b_edge_q > run_max_q) ? b_edge_q : run_max_q;

  assign res_push_o = b_valid_q && !res_full_i;

  always_comb begin
    res_o.edge_res    = b_edge_q;
    res_o.out_row     = b_row_q;
    res_o.out_col     = b_col_q;
    res_o.last_of_run = b_last_q;
    res_o.frame_done  = b_done_q;
    res_o.frame_min   = new_min;
    res_o.frame_max   = new_max;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b0;
      rem_q     <= '0;
      b_valid_q <= 1'b0;
      run_min_q <= MIN_RESET;
      run_max_q <= '0;
    end else begin
      busy_q    <= busy_d;
      rem_q     <= rem_d;
      b_valid_q <= b_valid_d;
      if (restart_i) begin
        run_min_q <= MIN_RESET;
        run_max_q <= '0;
      end else if (res_push_o) begin
        run_min_q <= b_done_q ? MIN_RESET : new_min;
        run_max_q <= b_done_q ? '0 : new_max;
      end
    end
  end

  a_busy_has_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (rem_q != '0) && !jq_empty_i)
    else $error("window sequencer busy without pending windows");

  a_done_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    b_valid_q && b_done_q |-> b_last_q)
    else $error("frame end result not marked last of its run");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    b_valid_q && res_full_i |=> b_valid_q && $stable(b_edge_q))
    else $error("stalled result changed");

endmodule

`default_nettype wire

### design/roberts_edge_magnitude_stream_unit.sv
// Roberts-cross edge magnitude over a raster-order pixel stream.
// Pixels enter on push/full/pixel_i, one per cycle while full is low. Results
// leave through a queue interface: while empty is low the oldest result sits
// on the result ports and is taken by pop.
// Each pixel past the first row and column completes the 2x2 window
// above-left of it, so results lag by one row and one column; a pixel in the
// last row or column also flushes the edge windows, up to four results for
// one pixel. Pixels that complete no window produce nothing.
// Path: front stage register, job queue, back end register, result queue.
// Throughput: one pixel per cycle; the back end sends one result per cycle
// while the result queue has room, so a flush burst of several results holds
// the input back once the four-entry job queue between the ends fills.
// Image size is set over the APB port (num_rows at 0x0, num_cols at 0x4);
// a write restarts the frame and is meant for an idle block.
// Reset: sizes go to 512x512, counters and frame min/max restart, both
// queues empty. The line store is not cleared.
// When pop is held low the result queue fills, then the back end and the job
// queue stall, and finally full rises; nothing is dropped.

`default_nettype none

module roberts_edge_magnitude_stream_unit #(
  parameter int unsigned MAX_COLS   = 1024,
  parameter int unsigned MAX_ROWS   = 1024,
  parameter int unsigned PIXEL_BITS = 8
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  input  wire logic        push,
  input  wire logic [7:0]  pixel_i,
  output logic             full,
  output logic             empty,
  input  wire logic        pop,
  output logic [10:0]      edge_res_o,
  output logic [9:0]       out_row_o,
  output logic [9:0]       out_col_o,
  output logic             last_of_run_o,
  output logic             frame_done_o,
  output logic [10:0]      frame_min_o,
  output logic [10:0]      frame_max_o
);

  import rems_pkg::*;

  localparam int unsigned COL_W    = $clog2(MAX_COLS);
  localparam int unsigned ROW_W    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int unsigned JOB_W    = 4 * PIXEL_BITS + ROW_W + COL_W + 4;
  localparam int unsigned JQ_DEPTH = 4;
  localparam int unsigned RQ_DEPTH = 4;
  localparam int unsigned RES_W    = $bits(result_t);

  logic [CFG_W-1:0] num_rows_q, num_cols_q;
  logic             cfg_wr;
  cfg_t             cfg;
  logic             jq_push, jq_full, jq_pop, jq_empty;
  logic [JOB_W-1:0] jq_wdata, jq_rdata;
  logic             res_push, res_full;
  result_t          res_in, res_out;
  logic [RES_W-1:0] res_rdata;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_rows_q <= SIZE_RESET;
      num_cols_q <= SIZE_RESET;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_NUM_ROWS: num_rows_q <= pwdata[CFG_W-1:0];
        REG_NUM_COLS: num_cols_q <= pwdata[CFG_W-1:0];
        default:      num_rows_q <= num_rows_q;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_NUM_ROWS: prdata = 32'(num_rows_q);
      REG_NUM_COLS: prdata = 32'(num_cols_q);
      default:      prdata = '0;
    endcase
  end

  always_comb begin
    cfg.restart  = cfg_wr;
    cfg.num_rows = num_rows_q;
    cfg.num_cols = num_cols_q;
  end

  rems_front #(
    .MAX_COLS   (MAX_COLS),
    .MAX_ROWS   (MAX_ROWS),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .push_i    (push),
    .pixel_i   (pixel_i),
    .full_o    (full),
    .jq_push_o (jq_push),
    .jq_data_o (jq_wdata),
    .jq_full_i (jq_full)
  );

  rems_fifo #(
    .WIDTH (JOB_W),
    .DEPTH (JQ_DEPTH)
  ) u_job_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (jq_push),
    .wdata_i (jq_wdata),
    .full_o  (jq_full),
    .pop_i   (jq_pop),
    .rdata_o (jq_rdata),
    .empty_o (jq_empty)
  );

  rems_back #(
    .MAX_COLS   (MAX_COLS),
    .MAX_ROWS   (MAX_ROWS),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .restart_i  (cfg.restart),
    .jq_empty_i (jq_empty),
    .jq_data_i  (jq_rdata),
    .jq_pop_o   (jq_pop),
    .res_push_o (res_push),
    .res_o      (res_in),
    .res_full_i (res_full)
  );

  rems_fifo #(
    .WIDTH (RES_W),
    .DEPTH (RQ_DEPTH)
  ) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .wdata_i (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .rdata_o (res_rdata),
    .empty_o (empty)
  );

  assign res_out       = res_rdata;
  assign edge_res_o    = res_out.edge_res;
  assign out_row_o     = res_out.out_row;
  assign out_col_o     = res_out.out_col;
  assign last_of_run_o = res_out.last_of_run;
  assign frame_done_o  = res_out.frame_done;
  assign frame_min_o   = res_out.frame_min;
  assign frame_max_o   = res_out.frame_max;

endmodule

`default_nettype wire

### tb/sv/roberts_edge_magnitude_stream_unit_tb.sv
module roberts_edge_magnitude_stream_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rems_pkg::*;

  localparam int unsigned MAX_COLS      = 1024;
  localparam int unsigned MAX_ROWS      = 1024;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned RANDOM_PIXELS = 400;
  localparam int unsigned REPORT_LIMIT  = 10;

  typedef enum int unsigned {PIX_UNIFORM, PIX_EXTREME, PIX_FLAT} pix_style_e;
  typedef enum int unsigned {RX_STREAM, RX_HALF, RX_SPARSE, RX_BURSTY} rx_mode_e;

  logic        clk_i;
  logic        rst_ni  = 1'b0;
  logic        psel    = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite  = 1'b0;
  logic [2:0]  paddr   = '0;
  logic [31:0] pwdata  = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        push    = 1'b0;
  logic [7:0]  pixel_i = '0;
  logic        full;
  logic        empty;
  logic        pop     = 1'b0;
  logic [10:0] edge_res_o;
  logic [9:0]  out_row_o;
  logic [9:0]  out_col_o;
  logic        last_of_run_o;
  logic        frame_done_o;
  logic [10:0] frame_min_o;
  logic [10:0] frame_max_o;

  roberts_edge_magnitude_stream_unit DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .push         (push),
    .pixel_i      (pixel_i),
    .full         (full),
    .empty        (empty),
    .pop          (pop),
    .edge_res_o   (edge_res_o),
    .out_row_o    (out_row_o),
    .out_col_o    (out_col_o),
    .last_of_run_o(last_of_run_o),
    .frame_done_o (frame_done_o),
    .frame_min_o  (frame_min_o),
    .frame_max_o  (frame_max_o)
  );

  // shadow of the block's state
  logic [7:0]        line_mem [MAX_COLS];
  logic [7:0]        left_px    = '0;
  logic [7:0]        upleft_px  = '0;
  int unsigned       row_cnt    = 0;
  int unsigned       col_cnt    = 0;
  logic [EDGE_W-1:0] min_seen   = MIN_RESET;
  logic [EDGE_W-1:0] max_seen   = '0;
  logic [CFG_W-1:0]  rows_reg   = SIZE_RESET;
  logic [CFG_W-1:0]  cols_reg   = SIZE_RESET;

  result_t     edge_results_due[$];
  logic [7:0]  pixels_to_send[$];
  logic [7:0]  flat_level   = 8'd128;

  int unsigned fail_cnt     = 0;
  int unsigned results_seen = 0;
  int unsigned pixels_taken = 0;
  int unsigned frames_done  = 0;
  int unsigned cfg_writes   = 0;

  int unsigned burst_left   = 1;
  int unsigned gap_left     = 0;
  rx_mode_e    rx_mode      = RX_STREAM;
  int unsigned rx_mode_left = 0;
  int unsigned rx_hold      = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic void note_failure(string msg);
    fail_cnt++;
    if (fail_cnt <= REPORT_LIMIT) $display("%0t: %s", $realtime, msg);
  endfunction

  function automatic int unsigned eff_size(logic [CFG_W-1:0] v, int unsigned lim);
    if (v == '0) return 1;
    if (v > lim) return lim;
    return v;
  endfunction

  function automatic logic [EDGE_W-1:0] window_magnitude(logic [7:0] a, logic [7:0] b,
                                                         logic [7:0] c, logic [7:0] d);
    int sa, sb, sc, sd, h, v, ld, s;
    sa = a;
    sb = b;
    sc = c;
    sd = d;
    h  = sa + sb - sc - sd;
    v  = sa - sb + sc - sd;
    ld = sa - sb - sc + sd;
    if (h < 0) h = -h;
    if (v < 0) v = -v;
    if (ld < 0) ld = -ld;
    s = h + v + 2 * ld;
    if (s > int'(EDGE_SAT)) s = int'(EDGE_SAT);
    return EDGE_W'(s);
  endfunction

  function automatic void new_frame();
    row_cnt  = 0;
    col_cnt  = 0;
    min_seen = MIN_RESET;
    max_seen = '0;
  endfunction

  function automatic result_t edge_window(logic [EDGE_W-1:0] val, int unsigned r,
                                          int unsigned c, logic done);
    result_t w;
    if (val < min_seen) min_seen = val;
    if (val > max_seen) max_seen = val;
    w.edge_res    = val;
    w.out_row     = COORD_W'(r);
    w.out_col     = COORD_W'(c);
    w.last_of_run = 1'b0;
    w.frame_done  = done;
    w.frame_min   = min_seen;
    w.frame_max   = max_seen;
    return w;
  endfunction

  // windows completed by one pixel, in the order the block emits them
  function automatic void predict_pixel(logic [7:0] px);
    int unsigned rows, cols, r, c, ci;
    logic [7:0]  up;
    bit          at_last_col, at_last_row;
    result_t     batch[$];
    rows        = eff_size(rows_reg, MAX_ROWS);
    cols        = eff_size(cols_reg, MAX_COLS);
    r           = row_cnt;
    c           = col_cnt;
    at_last_col = (c + 1 >= cols);
    at_last_row = (r + 1 >= rows);
    ci          = (c < MAX_COLS) ? c : MAX_COLS - 1;
    up          = line_mem[ci];
    if (r >= 1) begin
      if (c >= 1)
        batch.push_back(edge_window(window_magnitude(upleft_px, up, left_px, px),
                                    r - 1, c - 1, 1'b0));
      if (at_last_col)
        batch.push_back(edge_window(window_magnitude(up, up, px, px), r - 1, c, 1'b0));
    end
    if (at_last_row) begin
      if (c >= 1)
        batch.push_back(edge_window(window_magnitude(left_px, px, left_px, px),
                                    r, c - 1, 1'b0));
      if (at_last_col)
        batch.push_back(edge_window(window_magnitude(px, px, px, px), r, c, 1'b1));
    end
    if (batch.size() != 0) batch[batch.size() - 1].last_of_run = 1'b1;
    foreach (batch[i]) edge_results_due.push_back(batch[i]);
    upleft_px    = up;
    left_px      = px;
    line_mem[ci] = px;
    if (at_last_col) begin
      if (at_last_row) begin
        new_frame();
        frames_done++;
      end else begin
        col_cnt = 0;
        row_cnt = r + 1;
      end
    end else begin
      col_cnt = c + 1;
    end
  endfunction

  function automatic string show_result(result_t w);
    return $sformatf("edge=%0d row=%0d col=%0d last=%0b done=%0b min=%0d max=%0d",
                     w.edge_res, w.out_row, w.out_col, w.last_of_run, w.frame_done,
                     w.frame_min, w.frame_max);
  endfunction

  function automatic logic [7:0] pick_pixel(pix_style_e style);
    case (style)
      PIX_EXTREME: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
      PIX_FLAT: begin
        flat_level = flat_level + 8'($urandom_range(0, 4)) - 8'd2;
        return flat_level;
      end
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic void queue_pixels(int unsigned n, pix_style_e style);
    repeat (n) pixels_to_send.push_back(pick_pixel(style));
  endfunction

  // APB write, then read back; the write restarts the frame
  task automatic set_size(logic idx, logic [CFG_W-1:0] value);
    logic [31:0] rd;
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {21'($urandom), value};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (idx == REG_NUM_ROWS) rows_reg = value;
    else cols_reg = value;
    new_frame();
    cfg_writes++;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rd = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (rd !== {21'b0, value})
      note_failure($sformatf("register %0d read back %0h, expected %0h", idx, rd, value));
  endtask

  task automatic set_frame(logic [CFG_W-1:0] rows, logic [CFG_W-1:0] cols);
    set_size(REG_NUM_ROWS, rows);
    set_size(REG_NUM_COLS, cols);
    @(negedge clk_i);
  endtask

  // all pixels taken, all results back, then room for pixels that made no result
  task automatic wait_drained();
    while (pixels_to_send.size() != 0 || push || edge_results_due.size() != 0)
      @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // pixel sender: bursts and gaps
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      push    <= 1'b0;
      pixel_i <= '0;
    end else begin
      if (push && !full) begin
        predict_pixel(pixel_i);
        pixels_taken++;
      end
      if (!push || !full) begin
        if (gap_left != 0) begin
          gap_left = gap_left - 1;
          push <= 1'b0;
        end else if (pixels_to_send.size() != 0) begin
          push    <= 1'b1;
          pixel_i <= pixels_to_send.pop_front();
          if (burst_left <= 1) begin
            burst_left = ($urandom_range(0, 4) == 0) ? 64 : $urandom_range(1, 20);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left = burst_left - 1;
          end
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // result receiver: checks each transfer against the oldest expectation
  always @(posedge clk_i or negedge rst_ni) begin : rx_side
    result_t got;
    result_t want;
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        got.edge_res    = edge_res_o;
        got.out_row     = out_row_o;
        got.out_col     = out_col_o;
        got.last_of_run = last_of_run_o;
        got.frame_done  = frame_done_o;
        got.frame_min   = frame_min_o;
        got.frame_max   = frame_max_o;
        results_seen++;
        if (edge_results_due.size() == 0) begin
          note_failure($sformatf("unexpected result: %s", show_result(got)));
        end else begin
          want = edge_results_due.pop_front();
          if (got.edge_res !== want.edge_res || got.out_row !== want.out_row ||
              got.out_col !== want.out_col || got.last_of_run !== want.last_of_run ||
              got.frame_done !== want.frame_done || got.frame_min !== want.frame_min ||
              got.frame_max !== want.frame_max)
            note_failure($sformatf("mismatch: expected %s, got %s",
                                   show_result(want), show_result(got)));
        end
      end
      if (rx_mode_left == 0) begin
        rx_mode      = rx_mode_e'($urandom_range(0, 3));
        rx_mode_left = $urandom_range(20, 200);
      end else begin
        rx_mode_left = rx_mode_left - 1;
      end
      case (rx_mode)
        RX_STREAM: pop <= 1'b1;
        RX_HALF:   pop <= 1'($urandom_range(0, 1));
        RX_SPARSE: pop <= ($urandom_range(0, 3) == 0);
        default: begin
          if (rx_hold != 0) begin
            rx_hold = rx_hold - 1;
            pop <= 1'b0;
          end else begin
            pop <= 1'b1;
            rx_hold = $urandom_range(0, 1) ? $urandom_range(5, 25) : 0;
          end
        end
      endcase
    end
  end

  initial begin
    int unsigned npix;
    int unsigned kind;
    int unsigned guard;
    int unsigned random_pixels;
    pix_style_e  style;
    random_pixels = 0;
    foreach (line_mem[i]) line_mem[i] = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // checkerboard and extremes on a 3x3 frame
    set_frame(3, 3);
    pixels_to_send = '{8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'h00, 8'hFF};
    wait_drained();
    // size zero behaves as one: every pixel is a whole frame
    set_frame(0, 0);
    pixels_to_send = '{8'hFF, 8'h00};
    wait_drained();
    // single row, then single column
    set_frame(1, 4);
    pixels_to_send = '{8'hFF, 8'h00, 8'hFF, 8'h80};
    wait_drained();
    set_frame(4, 1);
    pixels_to_send = '{8'h00, 8'hFF, 8'h01, 8'hFE};
    wait_drained();
    // frame cut short, a register write restarts it
    set_frame(3, 3);
    pixels_to_send = '{8'h10, 8'hF0, 8'h33, 8'hCC};
    wait_drained();
    set_size(REG_NUM_COLS, 11'd2);
    @(negedge clk_i);
    pixels_to_send = '{8'hFF, 8'hFF, 8'h00, 8'h00, 8'hFF, 8'h00};
    wait_drained();

    // an oversized row register clamps to the maximum
    set_frame(11'd2047, 11'd3);
    queue_pixels(10, PIX_EXTREME);
    wait_drained();

    while (random_pixels < RANDOM_PIXELS) begin
      kind  = $urandom_range(0, 9);
      style = pix_style_e'($urandom_range(0, 2));
      if (kind != 9) set_frame(11'($urandom_range(0, 6)), 11'($urandom_range(0, 9)));
      npix = eff_size(rows_reg, MAX_ROWS) * eff_size(cols_reg, MAX_COLS);
      if (kind == 7 || kind == 8) npix = $urandom_range(1, npix);
      else npix = npix * $urandom_range(1, 3);
      queue_pixels(npix, style);
      random_pixels += npix;
      wait_drained();
    end

    guard = 0;
    while ((pixels_to_send.size() != 0 || push || edge_results_due.size() != 0) &&
           guard < 20000) begin
      @(negedge clk_i);
      guard++;
    end
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    if (pixels_to_send.size() != 0 || edge_results_due.size() != 0)
      note_failure($sformatf("%0d pixels unsent, %0d results never arrived",
                             pixels_to_send.size(), edge_results_due.size()));

    $display("Checked %0d edge results from %0d pixels, %0d frames completed",
             results_seen, pixels_taken, frames_done);
    $display("%0d size writes: sizes from 1x1 up, oversize clamping, cut frames, stalls",
             cfg_writes);
    if (fail_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #8_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
